FILE: src/triangle_unit_normal_assert.svh
// assertion helpers for triangle_unit_normal
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TUN_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TUN_ASSERT(label, clk, rst, prop, msg)
`define TUN_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: src/tun_pkg.sv
package tun_pkg;
   localparam int COORD_BITS_DEF = 24;
   localparam int PRESCALE_BITS  = 30;
   localparam int SQ_BITS        = 2 * PRESCALE_BITS;
   localparam int SUM_BITS       = SQ_BITS + 2;
   localparam int Q_BITS         = 15;
   localparam int NORM_BITS      = 16;
   localparam int NORM_ONE       = 16384;
   localparam int ACC_BITS       = 96;
endpackage

FILE: src/tun_cross.sv
module tun_cross #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [9*COORD_BITS-1:0] in_data,
   output logic out_valid,
   output logic out_degen,
   output logic [2:0] out_neg,
   output logic [tun_pkg::SUM_BITS-1:0] out_s,
   output logic [2:0][tun_pkg::ACC_BITS-1:0] out_r
);
   localparam int E  = COORD_BITS + 1;
   localparam int P  = 2 * E;
   localparam int N  = P + 1;
   localparam int LW = $clog2(N + 1);
   localparam int MW = (N > tun_pkg::PRESCALE_BITS) ? N : tun_pkg::PRESCALE_BITS;
   localparam int PB = tun_pkg::PRESCALE_BITS;
   localparam int STAGES = 8;

   logic [STAGES-1:0] valid_ff, valid_in;

   logic [2:0][E-1:0] e0_ff, e0_in, e1_ff, e1_in;
   logic [5:0][P-1:0] p_ff, p_in;
   logic [2:0][N-1:0] n_ff, n_in;
   logic [2:0][N-1:0] mag_ff, mag_in;
   logic [2:0] neg4_ff, neg4_in;
   logic [2:0][N-1:0] mag5_ff;
   logic [2:0] neg5_ff;
   logic [LW-1:0] ml_ff, ml_in;
   logic [2:0][PB-1:0] c_ff, c_in;
   logic [2:0] neg6_ff, neg7_ff, neg8_ff;
   logic degen6_ff, degen6_in, degen7_ff, degen8_ff;
   logic [2:0][tun_pkg::SQ_BITS-1:0] sq_ff, sq_in;
   logic [tun_pkg::SUM_BITS-1:0] s_ff, s_in;
   logic [2:0][tun_pkg::ACC_BITS-1:0] r_ff, r_in;

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e0_in[i] = E'($signed(in_data[(3+i)*COORD_BITS +: COORD_BITS]))
                  - E'($signed(in_data[i*COORD_BITS +: COORD_BITS]));
         e1_in[i] = E'($signed(in_data[(6+i)*COORD_BITS +: COORD_BITS]))
                  - E'($signed(in_data[i*COORD_BITS +: COORD_BITS]));
      end
   end

   always_comb begin
      p_in[0] = P'($signed(e0_ff[1]) * $signed(e1_ff[2]));
      p_in[1] = P'($signed(e0_ff[2]) * $signed(e1_ff[1]));
      p_in[2] = P'($signed(e0_ff[2]) * $signed(e1_ff[0]));
      p_in[3] = P'($signed(e0_ff[0]) * $signed(e1_ff[2]));
      p_in[4] = P'($signed(e0_ff[0]) * $signed(e1_ff[1]));
      p_in[5] = P'($signed(e0_ff[1]) * $signed(e1_ff[0]));
      for (int i = 0; i < 3; i++) begin
         n_in[i] = N'($signed(p_ff[2*i])) - N'($signed(p_ff[2*i+1]));
         neg4_in[i] = n_ff[i][N-1];
         mag_in[i] = n_ff[i][N-1] ? (N'(0) - n_ff[i]) : n_ff[i];
      end
   end

   // leading one of the widest magnitude
   logic [N-1:0] orv;
   always_comb begin
      orv = mag_ff[0] | mag_ff[1] | mag_ff[2];
      ml_in = '0;
      for (int j = 0; j < N; j++) begin
         if (orv[j]) ml_in = LW'(j + 1);
      end
   end

   logic [LW-1:0] sh;
   logic [MW-1:0] mx;
   always_comb begin
      sh = (ml_ff > LW'(PB)) ? (ml_ff - LW'(PB)) : '0;
      degen6_in = (ml_ff == '0);
      for (int i = 0; i < 3; i++) begin
         mx = MW'(mag5_ff[i]);
         mx = mx >> sh;
         c_in[i] = mx[PB-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = tun_pkg::SQ_BITS'(c_ff[i] * c_ff[i]);
         r_in[i] = tun_pkg::ACC_BITS'(sq_ff[i]) << (tun_pkg::Q_BITS * 2);
      end
      s_in = tun_pkg::SUM_BITS'(sq_ff[0]) + tun_pkg::SUM_BITS'(sq_ff[1])
           + tun_pkg::SUM_BITS'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         p_ff <= p_in;
         n_ff <= n_in;
         mag_ff <= mag_in;
         neg4_ff <= neg4_in;
         mag5_ff <= mag_ff;
         neg5_ff <= neg4_ff;
         ml_ff <= ml_in;
         c_ff <= c_in;
         neg6_ff <= neg5_ff;
         degen6_ff <= degen6_in;
         sq_ff <= sq_in;
         neg7_ff <= neg6_ff;
         degen7_ff <= degen6_ff;
         s_ff <= s_in;
         r_ff <= r_in;
         neg8_ff <= neg7_ff;
         degen8_ff <= degen7_ff;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_degen = degen8_ff;
   assign out_neg = neg8_ff;
   assign out_s = s_ff;
   assign out_r = r_ff;
endmodule

FILE: src/tun_cell.sv
module tun_cell #(
   parameter int BIT = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic in_degen,
   input  logic [2:0] in_neg,
   input  logic [2:0][tun_pkg::Q_BITS-1:0] in_q,
   input  logic [2:0][tun_pkg::ACC_BITS-1:0] in_l,
   input  logic [2:0][tun_pkg::ACC_BITS-1:0] in_d,
   input  logic [tun_pkg::SUM_BITS-1:0] in_s,
   input  logic [2:0][tun_pkg::ACC_BITS-1:0] in_r,
   output logic out_valid,
   output logic out_degen,
   output logic [2:0] out_neg,
   output logic [2:0][tun_pkg::Q_BITS-1:0] out_q,
   output logic [2:0][tun_pkg::ACC_BITS-1:0] out_l,
   output logic [2:0][tun_pkg::ACC_BITS-1:0] out_d,
   output logic [tun_pkg::SUM_BITS-1:0] out_s,
   output logic [2:0][tun_pkg::ACC_BITS-1:0] out_r
);
   localparam int W  = tun_pkg::ACC_BITS;
   localparam int QB = tun_pkg::Q_BITS;

   logic valid_ff;
   logic degen_ff;
   logic [2:0] neg_ff;
   logic [2:0][QB-1:0] q_ff, q_in;
   logic [2:0][W-1:0] l_ff, l_in, d_ff, d_in;
   logic [tun_pkg::SUM_BITS-1:0] s_ff;
   logic [2:0][W-1:0] r_ff;

   // try the next digit: L tracks (2q-1)^2*S, D tracks (2q-1)*S
   logic [W-1:0] s_w;
   logic [QB-1:0] t;
   logic signed [W-1:0] lt;
   logic ok;
   always_comb begin
      s_w = W'(in_s);
      for (int i = 0; i < 3; i++) begin
         t = in_q[i] | (QB'(1) << BIT);
         lt = $signed(in_l[i]) + ($signed(in_d[i]) <<< (BIT + 2))
            + $signed(s_w << (2 * BIT + 2));
         ok = (t <= QB'(tun_pkg::NORM_ONE)) && (lt <= $signed(in_r[i]));
         q_in[i] = ok ? t : in_q[i];
         l_in[i] = ok ? W'(lt) : in_l[i];
         d_in[i] = ok ? (in_d[i] + (s_w << (BIT + 1))) : in_d[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         degen_ff <= in_degen;
         neg_ff <= in_neg;
         q_ff <= q_in;
         l_ff <= l_in;
         d_ff <= d_in;
         s_ff <= in_s;
         r_ff <= in_r;
      end
   end

   assign out_valid = valid_ff;
   assign out_degen = degen_ff;
   assign out_neg = neg_ff;
   assign out_q = q_ff;
   assign out_l = l_ff;
   assign out_d = d_ff;
   assign out_s = s_ff;
   assign out_r = r_ff;
endmodule

FILE: src/triangle_unit_normal.sv
// channel  direction  ports                         word
// req      in         req_tvalid/tready/tdata       one triangle, nine coordinates
// rsp      out        rsp_tvalid/tready/tdata/tuser unit normal, degenerate flag
//
// One triangle accepted per cycle unless output stalls; 8 cross product and
// prescale stages, 15 rounding cells (one digit each), an output register.
// Synchronous active-high reset clears the valid pipeline only.
// The whole pipeline holds while rsp_tvalid is high and rsp_tready low.
module triangle_unit_normal #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic [((9*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // norm_x, norm_y, norm_z
   output logic [3*tun_pkg::NORM_BITS-1:0] rsp_tdata,
   // degenerate
   output logic [0:0] rsp_tuser
);
   localparam int QB = tun_pkg::Q_BITS;
   localparam int W  = tun_pkg::ACC_BITS;
   localparam int NB = tun_pkg::NORM_BITS;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic x_valid, x_degen;
   logic [2:0] x_neg;
   logic [tun_pkg::SUM_BITS-1:0] x_s;
   logic [2:0][W-1:0] x_r;

   tun_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(req_tvalid),
      .in_data(req_tdata[9*COORD_BITS-1:0]),
      .out_valid(x_valid),
      .out_degen(x_degen),
      .out_neg(x_neg),
      .out_s(x_s),
      .out_r(x_r)
   );

   logic [QB:0] c_valid, c_degen;
   logic [QB:0][2:0] c_neg;
   logic [QB:0][2:0][QB-1:0] c_q;
   logic [QB:0][2:0][W-1:0] c_l, c_d, c_r;
   logic [QB:0][tun_pkg::SUM_BITS-1:0] c_s;

   assign c_valid[0] = x_valid;
   assign c_degen[0] = x_degen;
   assign c_neg[0] = x_neg;
   assign c_s[0] = x_s;
   assign c_r[0] = x_r;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_q[0][i] = '0;
         c_l[0][i] = W'(x_s);
         c_d[0][i] = W'(0) - W'(x_s);
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_cell
      tun_cell #(.BIT(QB - 1 - k)) u_cell (
         .clock(clock),
         .reset(reset),
         .en(en),
         .in_valid(c_valid[k]),
         .in_degen(c_degen[k]),
         .in_neg(c_neg[k]),
         .in_q(c_q[k]),
         .in_l(c_l[k]),
         .in_d(c_d[k]),
         .in_s(c_s[k]),
         .in_r(c_r[k]),
         .out_valid(c_valid[k+1]),
         .out_degen(c_degen[k+1]),
         .out_neg(c_neg[k+1]),
         .out_q(c_q[k+1]),
         .out_l(c_l[k+1]),
         .out_d(c_d[k+1]),
         .out_s(c_s[k+1]),
         .out_r(c_r[k+1])
      );
   end

   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [3*NB-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic rsp_tuser_ff;
   logic [NB-1:0] qe;

   always_comb begin
      rsp_tvalid_in = en ? c_valid[QB] : rsp_tvalid_ff;
      for (int i = 0; i < 3; i++) begin
         qe = NB'(c_q[QB][i]);
         if (c_degen[QB]) begin
            rsp_tdata_in[i*NB +: NB] = '0;
         end else begin
            rsp_tdata_in[i*NB +: NB] = c_neg[QB][i] ? (NB'(0) - qe) : qe;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= c_degen[QB];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   localparam logic signed [NB-1:0] ONE_S = NB'(tun_pkg::NORM_ONE);
   logic signed [NB-1:0] nx_s;
   assign nx_s = rsp_tdata[NB-1:0];

`include "triangle_unit_normal_assert.svh"

   `TUN_ASSERT_ALWAYS(a_ready, clock, reset || (req_tready == (!rsp_tvalid || rsp_tready)), "ready")
   `TUN_ASSERT(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0, "degen")
   `TUN_ASSERT(a_range_x, clock, reset, rsp_tvalid |-> nx_s <= ONE_S && nx_s >= -ONE_S, "norm_x")
   `TUN_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "hold")
endmodule
